// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the relative rotation block.
// Define SYNTH to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("qrr assertion failed");
`define QRR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("qrr assertion failed");
`else
`define QRR_ASSERT(lbl, clk, rst, prop)
`define QRR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/qrr_pkg.sv =====
// Package for the quaternion relative rotation block: default widths.
// No dependencies.
`default_nettype none
package qrr_pkg;
   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF       = 14;
endpackage
`default_nettype wire

// ===== sv/quaternion_relative_rotation.sv =====
// Quaternion relative rotation: rsp = left * inverse(right) in signed fixed point.
// Depends on qrr_pkg and assert_macros.svh.
//
// Usage: present both quaternions on req_* with req_valid; the pair is
// transferred when req_valid and req_ready are both high. One result comes
// out on rsp_* per transfer, in order, with rsp_valid; it is taken when
// rsp_valid and rsp_ready are both high.
// The pipeline has one stage of multipliers, one of sums, one of magnitude and
// overflow check, one restoring-divider stage per quotient bit, and the output
// register. Throughput is one item per cycle while rsp_ready does not stall;
// the divider chain of COMPONENT_WIDTH compare-subtract stages sets the depth.
// A zero right quaternion yields all zero components and saturated low.
// Each stage holds its item while the next stage is full, so a stall on
// rsp_ready fills the bubbles first and only then drops req_ready; no item
// is lost or repeated. Reset clears all valid bits; the pipeline is empty
// and ready in the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"
module quaternion_relative_rotation
   import qrr_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_left_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_left_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_left_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_left_z,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_right_w,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_right_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_right_y,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_right_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_result_w,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_result_x,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_result_y,
   output logic signed [COMPONENT_WIDTH-1:0]      rsp_result_z,
   output logic                                   rsp_saturated
);
   localparam int CW = COMPONENT_WIDTH;
   localparam int PW = 2 * CW;           // one product
   localparam int NB = 2 * CW + 2;       // signed sum of four products
   localparam int NN = 2 * CW + 1;       // squared norm
   localparam int CB = 3 * CW + 1 + FRAC_BITS; // divider datapath

   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [NB-1:0] num_type;
   typedef logic [CB-1:0]        rem_type;
   typedef logic [CW-1:0]        quot_type;

   // stage 0: products
   logic     v0_ff;
   prod_type prod_ff [20];
   // stage 1: sums
   logic     v1_ff;
   num_type  num_ff [4];
   logic [NN-1:0] norm_ff;
   // divider stages, index 0 is the setup stage
   logic          vd_ff   [CW+1];
   rem_type       rem_ff  [CW+1][4];
   quot_type      q_ff    [CW+1][4];
   logic          neg_ff  [CW+1][4];
   logic          ovf_ff  [CW+1][4];
   logic          zero_ff [CW+1];
   logic [NN-1:0] dsr_ff  [CW+1];
   logic          rdyd    [CW+1];
   // output register
   logic          rsp_valid_ff;
   quot_type      res_ff [4];
   logic          sat_ff;

   logic rdy0, rdy1, rdy_out;

   assign rdy_out = !rsp_valid_ff || rsp_ready;
   assign rdyd[CW] = !vd_ff[CW] || rdy_out;
   assign rdy1 = !v1_ff || rdyd[0];
   assign rdy0 = !v0_ff || rdy1;
   assign req_ready = rdy0;

   // stage 0: twenty multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (rdy0) begin
         v0_ff <= req_valid;
      end
      if (rdy0 && req_valid) begin
         prod_ff[0]  <= req_right_w * req_right_w;
         prod_ff[1]  <= req_right_x * req_right_x;
         prod_ff[2]  <= req_right_y * req_right_y;
         prod_ff[3]  <= req_right_z * req_right_z;
         prod_ff[4]  <= req_left_w * req_right_w;
         prod_ff[5]  <= req_left_x * req_right_x;
         prod_ff[6]  <= req_left_y * req_right_y;
         prod_ff[7]  <= req_left_z * req_right_z;
         prod_ff[8]  <= req_left_x * req_right_w;
         prod_ff[9]  <= req_left_z * req_right_y;
         prod_ff[10] <= req_left_w * req_right_x;
         prod_ff[11] <= req_left_y * req_right_z;
         prod_ff[12] <= req_left_x * req_right_z;
         prod_ff[13] <= req_left_y * req_right_w;
         prod_ff[14] <= req_left_w * req_right_y;
         prod_ff[15] <= req_left_z * req_right_x;
         prod_ff[16] <= req_left_y * req_right_x;
         prod_ff[17] <= req_left_z * req_right_w;
         prod_ff[18] <= req_left_w * req_right_z;
         prod_ff[19] <= req_left_x * req_right_y;
      end
   end

   // stage 1: left times conjugate of right, and the squared norm
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= v0_ff;
      end
      if (rdy1 && v0_ff) begin
         norm_ff <= NN'($unsigned(prod_ff[0])) + NN'($unsigned(prod_ff[1]))
                  + NN'($unsigned(prod_ff[2])) + NN'($unsigned(prod_ff[3]));
         num_ff[0] <= NB'(prod_ff[4]) + NB'(prod_ff[5])
                    + NB'(prod_ff[6]) + NB'(prod_ff[7]);
         for (int c = 1; c < 4; c++) begin
            num_ff[c] <= NB'(prod_ff[4*c+4]) + NB'(prod_ff[4*c+5])
                       - NB'(prod_ff[4*c+6]) - NB'(prod_ff[4*c+7]);
         end
      end
   end

   // divider setup: magnitude, scale, overflow check
   logic    neg_in [4];
   rem_type mag_in [4];
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         neg_in[c] = num_ff[c][NB-1];
         mag_in[c] = CB'($unsigned(neg_in[c] ? -num_ff[c] : num_ff[c])) << FRAC_BITS;
      end
   end

   assign rdyd[0] = !vd_ff[0] || rdyd[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff[0] <= 1'b0;
      end else if (rdyd[0]) begin
         vd_ff[0] <= v1_ff;
      end
      if (rdyd[0] && v1_ff) begin
         zero_ff[0] <= (norm_ff == '0);
         dsr_ff[0]  <= norm_ff;
         for (int c = 0; c < 4; c++) begin
            rem_ff[0][c] <= mag_in[c];
            q_ff[0][c]   <= '0;
            neg_ff[0][c] <= neg_in[c];
            ovf_ff[0][c] <= mag_in[c] >= (CB'(norm_ff) << CW);
         end
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 1; k <= CW; k++) begin : g_div
      rem_type trial;
      assign trial = CB'(dsr_ff[k-1]) << (CW - k);
      if (k < CW) begin : g_rdy
         assign rdyd[k] = !vd_ff[k] || rdyd[k+1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (rdyd[k]) begin
            vd_ff[k] <= vd_ff[k-1];
         end
         if (rdyd[k] && vd_ff[k-1]) begin
            zero_ff[k] <= zero_ff[k-1];
            dsr_ff[k]  <= dsr_ff[k-1];
            for (int c = 0; c < 4; c++) begin
               neg_ff[k][c] <= neg_ff[k-1][c];
               ovf_ff[k][c] <= ovf_ff[k-1][c];
               if (rem_ff[k-1][c] >= trial) begin
                  rem_ff[k][c] <= rem_ff[k-1][c] - trial;
                  q_ff[k][c]   <= {q_ff[k-1][c][CW-2:0], 1'b1};
               end else begin
                  rem_ff[k][c] <= rem_ff[k-1][c];
                  q_ff[k][c]   <= {q_ff[k-1][c][CW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // clamp, restore sign, drop everything for a zero divisor
   localparam quot_type LimNeg = quot_type'(1) << (CW - 1);
   localparam quot_type LimPos = LimNeg - quot_type'(1);
   quot_type res_in [4];
   logic     sat_in;
   always_comb begin
      quot_type lim;
      quot_type qq;
      logic     clamp;
      sat_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         lim   = neg_ff[CW][c] ? LimNeg : LimPos;
         clamp = ovf_ff[CW][c] || (q_ff[CW][c] > lim);
         qq    = clamp ? lim : q_ff[CW][c];
         res_in[c] = neg_ff[CW][c] ? -qq : qq;
         if (zero_ff[CW]) begin
            res_in[c] = '0;
         end
         sat_in = sat_in || (clamp && !zero_ff[CW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_valid_ff <= vd_ff[CW];
      end
      if (rdy_out && vd_ff[CW]) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_w  = res_ff[0];
   assign rsp_result_x  = res_ff[1];
   assign rsp_result_y  = res_ff[2];
   assign rsp_result_z  = res_ff[3];
   assign rsp_saturated = sat_ff;

   `QRR_ASSERT(a_zero_norm_clean, clock, reset,
      (vd_ff[CW] && rdy_out && zero_ff[CW]) |=> (!rsp_saturated && rsp_result_w == '0))
   `QRR_ASSERT(a_sat_at_limit, clock, reset,
      (rsp_valid && rsp_saturated) |-> (rsp_result_w == LimPos || rsp_result_w == LimNeg
         || rsp_result_x == LimPos || rsp_result_x == LimNeg
         || rsp_result_y == LimPos || rsp_result_y == LimNeg
         || rsp_result_z == LimPos || rsp_result_z == LimNeg))
   `QRR_ASSERT(a_rem_below_dsr, clock, reset,
      (vd_ff[CW] && !zero_ff[CW] && !ovf_ff[CW][0]) |-> (rem_ff[CW][0] < CB'(dsr_ff[CW])))
   `QRR_ASSERT(a_ready_when_space, clock, reset,
      (!req_ready) |-> (v0_ff && v1_ff && rsp_valid_ff && !rsp_ready))
   `QRR_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)
endmodule
`default_nettype wire

// ===== bench/quaternion_relative_rotation_test.sv =====
// Self-checking bench for quaternion_relative_rotation: left * inverse(right).
// Depends on qrr_pkg and the RTL; computes expected quotients in wide integers.
`default_nettype none
module quaternion_relative_rotation_test
   import qrr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = COMPONENT_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = CW + 4;
   localparam int HOLD_OFF_LEN = 3 * LATENCY + 40;

   typedef logic signed [CW-1:0] comp_type;
   typedef struct packed {
      comp_type lw, lx, ly, lz, rw, rx, ry, rz;
   } quat_pair_type;
   typedef struct packed {
      comp_type w, x, y, z;
      logic     sat;
   } rotation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   comp_type req_left_w = '0, req_left_x = '0, req_left_y = '0, req_left_z = '0;
   comp_type req_right_w = '0, req_right_x = '0, req_right_y = '0, req_right_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   comp_type rsp_result_w, rsp_result_x, rsp_result_y, rsp_result_z;
   logic rsp_saturated;

   quaternion_relative_rotation u_dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_left_w, .req_left_x, .req_left_y, .req_left_z,
      .req_right_w, .req_right_x, .req_right_y, .req_right_z,
      .rsp_valid, .rsp_ready,
      .rsp_result_w, .rsp_result_x, .rsp_result_y, .rsp_result_z, .rsp_saturated
   );

   always #4 clock = ~clock;

   rotation_type expected_rotations[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_off_cycles = 0;
   int hold_off_requests = 0;
   int hold_off_seen = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Scale, divide with truncation toward zero, clamp.
   function automatic comp_type scale_divide(input logic signed [127:0] num,
                                             input logic signed [127:0] norm,
                                             inout logic sat);
      logic signed [127:0] mag, q, lim;
      logic neg;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag <<< FB) / norm;
      lim = (128'sd1 <<< (CW - 1)) - (neg ? 0 : 1);
      if (q > lim) begin
         q = lim;
         sat = 1'b1;
      end
      return neg ? comp_type'(-q) : comp_type'(q);
   endfunction

   function automatic rotation_type relative_rotation(input quat_pair_type p);
      logic signed [127:0] pw, px, py, pz, rw, rx, ry, rz, norm, nw, nx, ny, nz;
      rotation_type r;
      pw = p.lw; px = p.lx; py = p.ly; pz = p.lz;
      rw = p.rw; rx = p.rx; ry = p.ry; rz = p.rz;
      r = '0;
      norm = rw*rw + rx*rx + ry*ry + rz*rz;
      if (norm == 0) return r;
      nw = pw*rw + px*rx + py*ry + pz*rz;
      nx = px*rw + pz*ry - pw*rx - py*rz;
      ny = px*rz + py*rw - pw*ry - pz*rx;
      nz = py*rx + pz*rw - pw*rz - px*ry;
      r.w = scale_divide(nw, norm, r.sat);
      r.x = scale_divide(nx, norm, r.sat);
      r.y = scale_divide(ny, norm, r.sat);
      r.z = scale_divide(nz, norm, r.sat);
      return r;
   endfunction

   task automatic send_pair(input quat_pair_type p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_left_w, req_left_x, req_left_y, req_left_z,
       req_right_w, req_right_x, req_right_y, req_right_z} <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rotations.push_back(relative_rotation(p));
   endtask

   // long hold-off is counted here; tests only post a request
   always @(posedge clock) begin
      if (hold_off_seen != hold_off_requests) begin
         hold_off_seen <= hold_off_requests;
         hold_off_cycles <= HOLD_OFF_LEN;
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rotation_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rotations.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_rotations.pop_front();
            if (rsp_result_w !== want.w) report_mismatch("result_w", rsp_result_w, want.w);
            if (rsp_result_x !== want.x) report_mismatch("result_x", rsp_result_x, want.x);
            if (rsp_result_y !== want.y) report_mismatch("result_y", rsp_result_y, want.y);
            if (rsp_result_z !== want.z) report_mismatch("result_z", rsp_result_z, want.z);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", rsp_saturated, want.sat);
         end
      end
   end

   function automatic comp_type random_comp();
      case ($urandom_range(7))
         0: return comp_type'(-(1 << (CW - 1)));
         1: return comp_type'((1 << (CW - 1)) - 1);
         2: return '0;
         3: return comp_type'($urandom_range(2 * (1 << FB)) - (1 << FB));
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic quat_pair_type random_pair();
      quat_pair_type p;
      p = {random_comp(), random_comp(), random_comp(), random_comp(),
           random_comp(), random_comp(), random_comp(), random_comp()};
      // in about a quarter of the pairs make the right quaternion tiny, in some others zero
      if ($urandom_range(3) == 0) begin
         p.rw = comp_type'($urandom_range(4) - 2);
         p.rx = comp_type'($urandom_range(4) - 2);
         p.ry = '0;
         p.rz = '0;
      end else if ($urandom_range(9) == 0) begin
         p.rw = '0; p.rx = '0; p.ry = '0; p.rz = '0;
      end
      return p;
   endfunction

   task automatic test_directed();
      comp_type mn, mx, one, zc;
      mn = comp_type'(-(1 << (CW - 1)));
      mx = comp_type'((1 << (CW - 1)) - 1);
      one = comp_type'(1 << FB);
      zc = '0;
      send_pair({one, zc, zc, zc, one, zc, zc, zc});
      send_pair({mx, mx, mx, mx, one, zc, zc, zc});
      send_pair({mn, mn, mn, mn, one, zc, zc, zc});
      // zero right quaternion
      send_pair({mx, mn, mx, mn, zc, zc, zc, zc});
      // tiny norm forces clamping both ways
      send_pair({mx, mn, one, zc, comp_type'(1), zc, zc, zc});
      send_pair({mn, mn, mn, mn, mn, mn, mn, mn});
      send_pair({mx, mx, mx, mx, mx, mx, mx, mx});
      send_pair({mn, mx, mn, mx, mx, mn, mx, mn});
      send_pair({comp_type'(-1), comp_type'(-1), comp_type'(-1), comp_type'(-1),
                 comp_type'(-1), comp_type'(-1), comp_type'(-1), comp_type'(-1)});
      send_pair({comp_type'(1), comp_type'(-1), comp_type'(3), comp_type'(-3),
                 zc, zc, zc, mn});
      send_pair({comp_type'(12345), comp_type'(-2222), comp_type'(777), comp_type'(-9),
                 zc, comp_type'(3), zc, zc});
      send_pair({one, one, one, one, zc, zc, comp_type'(-1), zc});
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_pair(random_pair());
   endtask

   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_requests++;
      repeat (60) send_pair(random_pair());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(230, 0, 0);
      test_random(230, 59, 0);
      test_random(230, 0, 59);
      test_back_pressure();
      test_random(200, 18, 18);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
